[rtl/sgr_pkg.sv]
// Shared types and constants for the sixel glyph row decoder.
// Used by every module under rtl; depends on nothing else.
`default_nettype none

package sgr_pkg;

    localparam int BUFFER_COLUMNS = 32;
    localparam int PTR_W          = 5;
    localparam int COL_W          = 6;
    localparam int ROW_W          = 15;
    localparam int MAX_ROWS       = 12;
    localparam int ROW_CNT_W      = 4;
    localparam int GLYPH_W        = 7;
    localparam int BAND_ROWS      = 6;
    localparam int LOWER_BAND     = 16;

    localparam logic [7:0] CH_FIRST_DATA = 8'h3F;
    localparam logic [7:0] CH_LAST_DATA  = 8'h7E;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_SEMI       = 8'h3B;
    localparam logic [7:0] CH_BEL        = 8'h07;
    localparam logic [7:0] CH_HIGH       = 8'd128;

    localparam logic [GLYPH_W-1:0] SET_SIZE       = 7'd96;
    localparam logic [GLYPH_W-1:0] LAST_START     = 7'd95;
    localparam logic [ROW_CNT_W-1:0] MAX_HEIGHT   = 4'd12;

    typedef enum logic [1:0] {
        CFG_MATRIX_WIDTH  = 2'd0,
        CFG_MATRIX_HEIGHT = 2'd1,
        CFG_START_CHAR    = 2'd2
    } cfg_index_t;

    typedef logic [ROW_W-1:0] row_t;

    typedef struct packed {
        logic [3:0]         matrix_width;
        logic [3:0]         matrix_height;
        logic [GLYPH_W-1:0] start_char;
    } cfg_t;

    typedef struct packed {
        logic                     valid;
        row_t [MAX_ROWS-1:0]      rows;
        logic [ROW_CNT_W-1:0]     height;
        logic [GLYPH_W-1:0]       glyph;
        logic                     end_of_set;
    } glyph_req_t;

endpackage

`default_nettype wire

[rtl/sgr_front.sv]
// Input register, glyph column buffer and byte decode of the glyph row decoder.
// Depends on sgr_pkg; hands finished glyphs to sgr_emit as a snapshot request.
`default_nettype none

module sgr_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic [7:0]          data_byte,
    output logic                     in_stall,
    input  wire sgr_pkg::cfg_t       cfg,
    input  wire logic                emit_free,
    output sgr_pkg::glyph_req_t      req
);

    logic                           in_valid_reg;
    logic [7:0]                     in_byte_reg;
    logic [sgr_pkg::COL_W-1:0]      cols_reg  [sgr_pkg::BUFFER_COLUMNS];
    logic [sgr_pkg::COL_W-1:0]      cols_next [sgr_pkg::BUFFER_COLUMNS];
    logic [sgr_pkg::PTR_W-1:0]      ptr_reg, ptr_next;
    logic [sgr_pkg::GLYPH_W-1:0]    done_reg, done_next;
    logic                           fin_reg, fin_next;

    logic [sgr_pkg::GLYPH_W-1:0]    start_eff;
    logic [sgr_pkg::GLYPH_W-1:0]    expected;
    logic                           ignore;
    logic                           is_slash, is_data, ends_set, is_term;
    logic                           term_active, consume;
    logic [sgr_pkg::ROW_CNT_W-1:0]  height_eff;
    sgr_pkg::row_t [sgr_pkg::MAX_ROWS-1:0] rows;
    logic [7:0]                     data_val;

    always_comb
    begin
        start_eff = (cfg.start_char == '0) ? 7'd1 : cfg.start_char;
        expected  = (start_eff > sgr_pkg::LAST_START) ? '0 : sgr_pkg::SET_SIZE - start_eff;
        ignore    = fin_reg || (done_reg >= expected);

        is_slash = (in_byte_reg == sgr_pkg::CH_SLASH);
        is_data  = (in_byte_reg >= sgr_pkg::CH_FIRST_DATA) &&
                   (in_byte_reg <= sgr_pkg::CH_LAST_DATA);
        ends_set = (in_byte_reg == sgr_pkg::CH_BEL) || (in_byte_reg > sgr_pkg::CH_HIGH);
        is_term  = ends_set || (in_byte_reg == sgr_pkg::CH_SEMI);

        term_active = in_valid_reg && !ignore && is_term;
        consume     = in_valid_reg && (!term_active || emit_free);
        in_stall    = in_valid_reg && !consume;

        height_eff = (cfg.matrix_height > sgr_pkg::MAX_HEIGHT) ? sgr_pkg::MAX_HEIGHT
                                                               : cfg.matrix_height;
        for (int y = 0; y < sgr_pkg::MAX_ROWS; y++)
        begin
            for (int x = 0; x < sgr_pkg::ROW_W; x++)
            begin
                rows[y][x] = (4'(x) < cfg.matrix_width) &&
                    cols_reg[((y >= sgr_pkg::BAND_ROWS) ? sgr_pkg::LOWER_BAND : 0) + x]
                            [y % sgr_pkg::BAND_ROWS];
            end
        end

        req.valid      = term_active && emit_free;
        req.rows       = rows;
        req.height     = height_eff;
        req.glyph      = done_reg;
        req.end_of_set = ends_set;
    end

    always_comb
    begin
        cols_next = cols_reg;
        ptr_next  = ptr_reg;
        done_next = done_reg;
        fin_next  = fin_reg;
        data_val  = in_byte_reg - sgr_pkg::CH_FIRST_DATA;
        if (consume && !ignore)
        begin
            if (is_slash)
            begin
                ptr_next = sgr_pkg::PTR_W'(sgr_pkg::LOWER_BAND);
            end
            else if (is_data)
            begin
                if (ptr_reg[3:0] != cfg.matrix_width)
                begin
                    cols_next[ptr_reg] = data_val[sgr_pkg::COL_W-1:0];
                    ptr_next           = ptr_reg + 1'b1;
                end
            end
            else if (is_term)
            begin
                for (int i = 0; i < sgr_pkg::BUFFER_COLUMNS; i++)
                begin
                    cols_next[i] = '0;
                end
                ptr_next  = '0;
                done_next = done_reg + 1'b1;
                fin_next  = fin_reg || ends_set;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            ptr_reg      <= '0;
            done_reg     <= '0;
            fin_reg      <= 1'b0;
            for (int i = 0; i < sgr_pkg::BUFFER_COLUMNS; i++)
            begin
                cols_reg[i] <= '0;
            end
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            ptr_reg  <= ptr_next;
            done_reg <= done_next;
            fin_reg  <= fin_next;
            cols_reg <= cols_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            in_byte_reg <= data_byte;
        end
    end

    a_term_resets_pointer: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid |=> (ptr_reg == '0))
        else $error("column pointer not cleared after a glyph ended");

    a_term_counts_glyph: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid |=> (done_reg == $past(done_reg) + 1'b1))
        else $error("glyph count did not advance on a glyph end");

    a_stall_only_on_term: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && is_term && !emit_free))
        else $error("input stalled without a waiting glyph end");

endmodule

`default_nettype wire

[rtl/sgr_emit.sv]
// Row emitter and result register of the glyph row decoder.
// Depends on sgr_pkg; takes glyph snapshots from sgr_front and sends each glyph's rows in order, one result per row.
`default_nettype none

module sgr_emit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire sgr_pkg::glyph_req_t         req,
    output logic                             emit_free,
    input  wire logic                        out_stall,
    output logic                             out_valid,
    output logic [sgr_pkg::ROW_W-1:0]        row_bits,
    output logic [sgr_pkg::ROW_CNT_W-1:0]    row_index,
    output logic [sgr_pkg::GLYPH_W-1:0]      glyph_index,
    output logic                             last_row,
    output logic                             end_of_set
);

    logic                                  busy_reg, busy_next;
    sgr_pkg::row_t [sgr_pkg::MAX_ROWS-1:0] rows_reg;
    logic [sgr_pkg::ROW_CNT_W-1:0]         height_reg;
    logic [sgr_pkg::ROW_CNT_W-1:0]         cnt_reg, cnt_next;
    logic [sgr_pkg::GLYPH_W-1:0]           glyph_reg;
    logic                                  eos_reg;

    logic                                  out_valid_reg;
    logic [sgr_pkg::ROW_W-1:0]             row_bits_reg;
    logic [sgr_pkg::ROW_CNT_W-1:0]         row_index_reg;
    logic [sgr_pkg::GLYPH_W-1:0]           glyph_index_reg;
    logic                                  last_row_reg;
    logic                                  end_of_set_reg;

    logic out_free, push, push_last;

    always_comb
    begin
        out_free  = !out_valid_reg || !out_stall;
        push      = busy_reg && out_free;
        push_last = push && ((cnt_reg + 1'b1) == height_reg);
        emit_free = !busy_reg || push_last;

        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (req.valid)
        begin
            busy_next = (req.height != '0);
            cnt_next  = '0;
        end
        else if (push)
        begin
            busy_next = !push_last;
            cnt_next  = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_free)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid)
        begin
            rows_reg   <= req.rows;
            height_reg <= req.height;
            glyph_reg  <= req.glyph;
            eos_reg    <= req.end_of_set;
        end
        if (push)
        begin
            row_bits_reg    <= rows_reg[cnt_reg];
            row_index_reg   <= cnt_reg;
            glyph_index_reg <= glyph_reg;
            last_row_reg    <= push_last;
            end_of_set_reg  <= eos_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign row_bits    = row_bits_reg;
    assign row_index   = row_index_reg;
    assign glyph_index = glyph_index_reg;
    assign last_row    = last_row_reg;
    assign end_of_set  = end_of_set_reg;

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg < height_reg))
        else $error("row counter ran past the glyph height");

    a_snapshot_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && (req.height != '0)) |=> (busy_reg && (cnt_reg == '0)))
        else $error("glyph snapshot did not start emission");

    a_rows_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && !last_row_reg) |=> out_valid_reg)
        else $error("gap inside the rows of one glyph");

endmodule

`default_nettype wire

[rtl/sixel_glyph_row_decoder.sv]
// Top level of the sixel glyph row decoder: configuration registers and the two stages.
// Depends on sgr_pkg, sgr_front and sgr_emit.
`default_nettype none

// Decodes DRCS soft-font sixel data one byte per request. Data bytes, '/'
// and ignored bytes are taken one per cycle without stalling. A glyph end
// (';', BEL or a byte above 128) snapshots the column buffer into the row
// emitter and clears it, so data for the next glyph keeps flowing at one byte
// per cycle while the emitter sends matrix_height row results, one per cycle
// when the output is not stalled. A second glyph end waits in the input
// register until the emitter has issued its final row, so a stream of bare
// terminators runs at the emitter's pace, with heights above 12 counted as
// 12 and a zero height sending no rows. A row result passes the emitter's
// snapshot registers, then its output registers. Configuration is written
// through cfg_valid/cfg_ready, always ready, and must only change while idle.
module sixel_glyph_row_decoder (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [7:0]                data_byte,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [sgr_pkg::ROW_W-1:0]      row_bits,
    output logic [sgr_pkg::ROW_CNT_W-1:0]  row_index,
    output logic [sgr_pkg::GLYPH_W-1:0]    glyph_index,
    output logic                           last_row,
    output logic                           end_of_set,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [1:0]                cfg_index,
    input  wire logic [sgr_pkg::GLYPH_W-1:0] cfg_data
);

    sgr_pkg::cfg_t       cfg_reg;
    sgr_pkg::glyph_req_t req;
    logic                emit_free;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.matrix_width  <= 4'd15;
            cfg_reg.matrix_height <= 4'd12;
            cfg_reg.start_char    <= 7'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sgr_pkg::CFG_MATRIX_WIDTH:  cfg_reg.matrix_width  <= cfg_data[3:0];
                sgr_pkg::CFG_MATRIX_HEIGHT: cfg_reg.matrix_height <= cfg_data[3:0];
                sgr_pkg::CFG_START_CHAR:    cfg_reg.start_char    <= cfg_data;
                default:                    cfg_reg               <= cfg_reg;
            endcase
        end
    end

    sgr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .data_byte (data_byte),
        .in_stall  (in_stall),
        .cfg       (cfg_reg),
        .emit_free (emit_free),
        .req       (req)
    );

    sgr_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .emit_free   (emit_free),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .row_bits    (row_bits),
        .row_index   (row_index),
        .glyph_index (glyph_index),
        .last_row    (last_row),
        .end_of_set  (end_of_set)
    );

endmodule

`default_nettype wire
